FILE: rtl/pfd_pkg.sv
// Package for the pixel sensor frame decoder.
// Holds the item, result, queue entry and geometry types, the register and
// mode codes and the matrix order function. No dependencies.
package pfd_pkg;

	localparam int MAX_ROWS = 256;
	localparam int MAX_COLS = 256;
	localparam int MAX_MATS = 4;

	localparam int GEO_W   = 9;                    // rows / cols register width
	localparam int MAT_W   = 3;                    // mats register width
	localparam int ROW_W   = $clog2(MAX_ROWS);
	localparam int COL_W   = $clog2(MAX_COLS);
	localparam int MCNT_W  = 2;
	localparam int WC_W    = 20;
	localparam int PROD_W  = 2 * GEO_W;
	localparam int PIVOT_W = 18;
	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	localparam logic [WC_W-1:0] WC_MAX = '1;

	// Configuration register indexes
	localparam logic [2:0] REG_DETECTOR = 3'd0;
	localparam logic [2:0] REG_MODE     = 3'd1;
	localparam logic [2:0] REG_ROWS     = 3'd2;
	localparam logic [2:0] REG_COLS     = 3'd3;
	localparam logic [2:0] REG_MATS     = 3'd4;

	// Readout modes
	localparam logic [1:0] MODE_THREE_FRAME = 2'd0;
	localparam logic [1:0] MODE_TWO_FRAME   = 2'd1;
	localparam logic [1:0] MODE_ZS          = 2'd2;

	// Detector types
	localparam logic [1:0] DET_FIRST     = 2'd0;
	localparam logic [1:0] DET_NEW_ORDER = 2'd1;
	localparam logic [1:0] DET_THIRD     = 2'd2;
	localparam logic [1:0] DET_LARGE     = 2'd3;

	// Item kinds
	localparam logic ITEM_START = 1'b0;
	localparam logic ITEM_DATA  = 1'b1;

	typedef struct packed {
		logic               mode;
		logic [PIVOT_W-1:0] pivot;
		logic [31:0]        data_word;
		logic               last_word;
	} item_t;

	typedef struct packed {
		logic [9:0]  pix_x;
		logic [8:0]  pix_y;
		logic [1:0]  frame_num;
		logic [11:0] adc_value;
		logic        after_pivot;
		logic        size_error;
		logic        board_end;
	} result_t;

	// Clamped geometry and derived settings, shared by front and back
	typedef struct packed {
		logic [1:0]        det;
		logic              raw;
		logic [1:0]        nf;
		logic [GEO_W-1:0]  nr;
		logic [GEO_W-1:0]  nc;
		logic [MAT_W-1:0]  nm;
		logic [PROD_W-1:0] prod;   // nr * nc, registered
	} geom_t;

	// One queue entry: a classified data word
	typedef struct packed {
		logic            raw;
		logic [31:0]     word;
		logic            last;
		logic [9:0]      x;
		logic [8:0]      y;
		logic [1:0]      fr;
		logic            piv;
		logic [WC_W-1:0] wc;
		logic            ovr;
	} cmd_t;

	function automatic logic [1:0] order_of(logic [1:0] det, logic [1:0] m);
		logic [1:0] o;
		if (det == DET_NEW_ORDER) begin
			o = m;
		end else begin
			case (m)
				2'd0:    o = 2'd3;
				2'd1:    o = 2'd1;
				2'd2:    o = 2'd2;
				default: o = 2'd0;
			endcase
		end
		return o;
	endfunction

endpackage

FILE: rtl/pfd_front.sv
// Front end of the frame decoder: accepts items, keeps the readout counters
// and pushes classified data words into the queue. Uses pfd_pkg.
module pfd_front
	import pfd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  geom_t geom,
	input  logic  item_valid,
	input  item_t item,
	output logic  item_stall,
	input  logic  q_full,
	output logic  q_push,
	output cmd_t  q_cmd
);

	logic [ROW_W-1:0]   row_q;
	logic [COL_W-1:0]   col_q;
	logic [1:0]         frame_q;
	logic [MCNT_W-1:0]  mat_q;
	logic [PIVOT_W-1:0] pivot_q;
	logic [WC_W-1:0]    wc_q;
	logic               ovr_q;

	logic               accept;
	logic [1:0]         order;
	logic [WC_W-1:0]    wc_n;
	logic [MAT_W-1:0]   mat_i;
	logic [1:0]         fr_i;
	logic [GEO_W:0]     col_i;
	logic [GEO_W:0]     row_i;
	logic [ROW_W-1:0]   row_n;
	logic [COL_W-1:0]   col_n;
	logic [1:0]         frame_n;
	logic [MCNT_W-1:0]  mat_n;
	logic               ovr_n;
	logic [PIVOT_W-1:0] pix_index;

	assign item_stall = q_full;
	assign accept     = item_valid && !item_stall;
	assign q_push     = accept && (item.mode == ITEM_DATA);

	assign order     = order_of(geom.det, mat_q);
	assign pix_index = PIVOT_W'({row_q, 7'b0}) | PIVOT_W'(col_q);
	assign wc_n      = (wc_q == WC_MAX) ? wc_q : wc_q + WC_W'(1);

	// Next counter position: matrix innermost, then frame, column, row
	always_comb begin
		row_n   = row_q;
		col_n   = col_q;
		frame_n = frame_q;
		mat_n   = mat_q;
		ovr_n   = ovr_q;
		mat_i   = MAT_W'(mat_q) + MAT_W'(1);
		fr_i    = frame_q + 2'd1;
		col_i   = (GEO_W + 1)'(col_q) + (GEO_W + 1)'(1);
		row_i   = (GEO_W + 1)'(row_q);
		if (col_i >= (GEO_W + 1)'(geom.nc)) begin
			col_i = '0;
			row_i = (GEO_W + 1)'(row_q) + (GEO_W + 1)'(1);
		end
		if (mat_i >= geom.nm) begin
			mat_n = '0;
			if (fr_i >= geom.nf) begin
				frame_n = '0;
				// the last pixel of a matrix is never sent: wrap one early
				if (row_i >= (GEO_W + 1)'(geom.nr) ||
				    (row_i == (GEO_W + 1)'(geom.nr) - (GEO_W + 1)'(1) &&
				     col_i == (GEO_W + 1)'(geom.nc) - (GEO_W + 1)'(1))) begin
					row_n = '0;
					col_n = '0;
					ovr_n = 1'b1;
				end else begin
					row_n = ROW_W'(row_i);
					col_n = COL_W'(col_i);
				end
			end else begin
				frame_n = fr_i;
			end
		end else begin
			mat_n = MCNT_W'(mat_i);
		end
	end

	always_comb begin
		q_cmd.raw  = geom.raw;
		q_cmd.word = item.data_word;
		q_cmd.last = item.last_word;
		q_cmd.x    = 10'(11'(col_q) + 11'(order) * 11'(geom.nc));
		q_cmd.y    = 9'(row_q);
		q_cmd.fr   = frame_q;
		q_cmd.piv  = (pix_index >= pivot_q);
		q_cmd.wc   = geom.raw ? wc_n : wc_q;
		q_cmd.ovr  = ovr_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q   <= '0;
			col_q   <= '0;
			frame_q <= '0;
			mat_q   <= '0;
			pivot_q <= '0;
			wc_q    <= '0;
			ovr_q   <= 1'b0;
		end else if (accept) begin
			if (item.mode == ITEM_START) begin
				pivot_q <= item.pivot;
				row_q   <= '0;
				col_q   <= '0;
				frame_q <= '0;
				mat_q   <= '0;
				wc_q    <= '0;
				ovr_q   <= 1'b0;
			end else if (geom.raw) begin
				row_q   <= row_n;
				col_q   <= col_n;
				frame_q <= frame_n;
				mat_q   <= mat_n;
				wc_q    <= wc_n;
				ovr_q   <= ovr_n;
			end
		end
	end

endmodule

FILE: rtl/pfd_queue.sv
// Two-entry queue between the front and back of the frame decoder.
// Uses the cmd_t entry type from pfd_pkg.
module pfd_queue
	import pfd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output cmd_t head
);

	cmd_t              entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full      = (count_q == QCNT_W'(QDEPTH));
	assign not_empty = (count_q != '0);
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue pop while empty");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + QCNT_W'(1)))
		else $error("queue count did not advance on push");

endmodule

FILE: rtl/pfd_back.sv
// Back end of the frame decoder: pops classified words, unpacks zero-suppressed
// hits, checks the board size and holds the result register. Uses pfd_pkg.
module pfd_back
	import pfd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  geom_t   geom,
	input  logic    q_not_empty,
	input  cmd_t    q_head,
	output logic    q_pop,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	result_t          res_q;
	logic             res_valid_q;
	result_t          res_n;

	logic [7:0]       b0;
	logic [7:0]       b1;
	logic [7:0]       b2;
	logic [1:0]       o;
	logic [8:0]       c_large;
	logic [8:0]       r_large;
	logic [6:0]       c_small;
	logic [9:0]       mir_x;
	logic [9:0]       mir_y;
	logic [3:0]       nmf;
	logic [WC_W-1:0]  expect_wc;

	function automatic logic [9:0] mirror(logic [GEO_W-1:0] n, logic [8:0] v);
		logic [9:0] top;
		logic [9:0] vv;
		top = {n, 1'b0};
		vv  = {1'b0, v};
		return (vv + 10'd1 >= top) ? 10'd0 : top - 10'd1 - vv;
	endfunction

	assign q_pop = q_not_empty && (!res_valid_q || !result_stall);

	assign b0      = q_head.word[31:24];
	assign b1      = q_head.word[23:16];
	assign b2      = q_head.word[15:8];
	assign o       = order_of(geom.det, 2'd3 - b0[7:6]);
	assign c_large = {b1[4:0], b2[7:4]};
	assign r_large = {b0[5:0], b1[7:5]};
	assign c_small = {b1[2:0], b2[7:4]};
	assign mir_x   = mirror(geom.nc, c_large);
	assign mir_y   = mirror(geom.nr, r_large);

	// expected raw word count: (rows*cols - 1) * mats * frames
	assign nmf       = 4'(geom.nm) * 4'(geom.nf);
	assign expect_wc = WC_W'(16'(geom.prod - PROD_W'(1)) * 20'(nmf));

	always_comb begin
		res_n.adc_value = q_head.word[11:0];
		res_n.board_end = q_head.last;
		if (q_head.raw) begin
			res_n.pix_x       = q_head.x;
			res_n.pix_y       = q_head.y;
			res_n.frame_num   = q_head.fr;
			res_n.after_pivot = q_head.piv;
			res_n.size_error  = q_head.last && ((q_head.wc != expect_wc) || q_head.ovr);
		end else begin
			res_n.frame_num   = 2'd0;
			res_n.after_pivot = 1'b0;
			res_n.size_error  = 1'b0;
			if (geom.det == DET_LARGE) begin
				res_n.pix_x = (o >= 2'd2) ? mir_x : {1'b0, c_large};
				res_n.pix_y = (o == 2'd1 || o == 2'd2) ? 9'(mir_y) : r_large;
			end else begin
				res_n.pix_x = 10'(11'(c_small) + 11'(o) * 11'(geom.nc));
				res_n.pix_y = {1'b0, b0[2:0], b1[7:3]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_q <= res_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (q_pop) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

FILE: rtl/pixel_sensor_frame_decoder.sv
// Top level of the pixel sensor frame decoder: configuration registers,
// clamped geometry, and the front / queue / back instances. Uses pfd_pkg.
//
// The decoder takes one item per clock cycle while the queue is not full. A
// start item loads the pivot and clears the counters and gives no result;
// every data word gives exactly one result, which passes through the
// two-entry queue and then the output register. The front end's counter
// update sets that rate. The input stalls only while the queue is full,
// which happens only when the result side stalls. The rows x cols product
// behind the board size check is registered from the configuration, so an
// item may follow a configuration write in the next cycle.
module pixel_sensor_frame_decoder
	import pfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  item_t      item,
	output logic       result_valid,
	input  logic       result_stall,
	output result_t    result,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [8:0] cfg_data
);

	logic [1:0]        det_q;
	logic [1:0]        mode_q;
	logic [GEO_W-1:0]  rows_q;
	logic [GEO_W-1:0]  cols_q;
	logic [MAT_W-1:0]  mats_q;
	logic [PROD_W-1:0] prod_q;

	logic [GEO_W-1:0]  nr;
	logic [GEO_W-1:0]  nc;
	logic [MAT_W-1:0]  nm;
	geom_t             geom;

	logic              q_full;
	logic              q_push;
	cmd_t              q_cmd;
	logic              q_pop;
	logic              q_not_empty;
	cmd_t              q_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			det_q  <= DET_FIRST;
			mode_q <= MODE_THREE_FRAME;
			rows_q <= GEO_W'(256);
			cols_q <= GEO_W'(66);
			mats_q <= MAT_W'(4);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DETECTOR: det_q  <= cfg_data[1:0];
				REG_MODE:     mode_q <= cfg_data[1:0];
				REG_ROWS:     rows_q <= cfg_data[GEO_W-1:0];
				REG_COLS:     cols_q <= cfg_data[GEO_W-1:0];
				REG_MATS:     mats_q <= cfg_data[MAT_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp geometry into the supported range
	assign nr = (rows_q == '0) ? GEO_W'(1) :
	            (rows_q > GEO_W'(MAX_ROWS)) ? GEO_W'(MAX_ROWS) : rows_q;
	assign nc = (cols_q == '0) ? GEO_W'(1) :
	            (cols_q > GEO_W'(MAX_COLS)) ? GEO_W'(MAX_COLS) : cols_q;
	assign nm = (mats_q == '0) ? MAT_W'(1) :
	            (mats_q > MAT_W'(MAX_MATS)) ? MAT_W'(MAX_MATS) : mats_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_q <= PROD_W'(256 * 66);
		end else begin
			prod_q <= PROD_W'(nr) * PROD_W'(nc);
		end
	end

	always_comb begin
		geom.det  = det_q;
		geom.raw  = (mode_q == MODE_THREE_FRAME) || (mode_q == MODE_TWO_FRAME);
		geom.nf   = (mode_q == MODE_THREE_FRAME) ? 2'd3 : 2'd2;
		geom.nr   = nr;
		geom.nc   = nc;
		geom.nm   = nm;
		geom.prod = prod_q;
	end

	pfd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.geom       (geom),
		.item_valid (item_valid),
		.item       (item),
		.item_stall (item_stall),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_cmd      (q_cmd)
	);

	pfd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (q_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	pfd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.geom         (geom),
		.q_not_empty  (q_not_empty),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
